[hdl/abts_pkg.sv]
// Shared types, constants and helpers of the AABB tile body step unit.
// Depends on nothing; every other file of the block imports it.
package abts_pkg;

    // fixed point format of positions, velocities and body size
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int BODY_W    = 23;

    // wide sums that saturate back to DATA_W
    localparam int SAT_W = (FRAC_BITS + 18 > 36) ? FRAC_BITS + 18 : 36;

    // collision datapath widths (twice-scale distances and depths)
    localparam int K_W    = DATA_W + 2;
    localparam int DIST_W = DATA_W + 3;
    localparam int DEP_W  = DIST_W - 1;
    localparam int MAG_W  = DEP_W - 1;
    localparam int PROD_W = MAG_W + BODY_W;

    // configuration port
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_TILES   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_STEP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BODY_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BODY_HEIGHT  = 3'd4;

    localparam logic [30:0] RST_SPEED_LIMIT  = 31'd65536;
    localparam logic [14:0] RST_WRAP_TILES   = 15'd4096;
    localparam logic [15:0] RST_GRAVITY_STEP = 16'd1338;
    localparam logic [22:0] RST_BODY_WIDTH   = 23'd65536;
    localparam logic [22:0] RST_BODY_HEIGHT  = 23'd131072;

    // command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_MOVE    = 2'd1;
    localparam logic [1:0] CMD_COLLIDE = 2'd2;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // saturation bounds at the wide width
    localparam logic signed [SAT_W-1:0] SAT_MAX = {{(SAT_W-DATA_W){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [SAT_W-1:0] SAT_MIN = {{(SAT_W-DATA_W){1'b1}}, 32'h8000_0000};

    typedef struct packed {
        logic [30:0] speed_limit;
        logic [14:0] wrap_tiles;
        logic [15:0] gravity_step;
        logic [22:0] body_width;
        logic [22:0] body_height;
    } cfg_t;

    // decoded command: arg fields hold the raw load position or, for a
    // collide, the tile centre folded with the body size (2*t - size)
    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [K_W-1:0]   arg_x;
        logic signed [K_W-1:0]   arg_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic                    ground;
    } op_t;

    // clip a wide signed sum to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        if (v > SAT_MAX)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < SAT_MIN)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[DATA_W-1:0];
    endfunction

endpackage

[hdl/abts_in_if.sv]
// Input channel of the AABB tile body step unit: valid/ready plus one command.
// Depends on abts_pkg for field widths.
interface abts_in_if;
    import abts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] arg_x;
    logic signed [DATA_W-1:0] arg_y;
    logic signed [DATA_W-1:0] load_vel_x;
    logic signed [DATA_W-1:0] load_vel_y;
    logic                     ground_test;

    modport source (
        output valid, cmd, arg_x, arg_y, load_vel_x, load_vel_y, ground_test,
        input  ready
    );

    modport sink (
        input  valid, cmd, arg_x, arg_y, load_vel_x, load_vel_y, ground_test,
        output ready
    );

endinterface

[hdl/abts_out_if.sv]
// Result channel of the AABB tile body step unit: valid/ready plus the body state.
// Depends on abts_pkg for field widths.
interface abts_out_if;
    import abts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_pos_x;
    logic signed [DATA_W-1:0] out_pos_y;
    logic signed [DATA_W-1:0] out_vel_x;
    logic signed [DATA_W-1:0] out_vel_y;
    logic                     out_on_ground;

    modport source (
        output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_on_ground,
        input  ready
    );

    modport sink (
        input  valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_on_ground,
        output ready
    );

endinterface

[hdl/abts_front.sv]
// Front end: accepts commands, decodes them and folds the body size into
// collide arguments. Depends on abts_pkg and abts_in_if.
module abts_front (
    abts_in_if.sink        item,
    input  abts_pkg::cfg_t cfg,
    input  logic           can_push,
    output logic           push,
    output abts_pkg::op_t  push_op
);
    import abts_pkg::*;

    logic signed [K_W-1:0] raw_x;
    logic signed [K_W-1:0] raw_y;
    logic signed [K_W-1:0] fold_x;
    logic signed [K_W-1:0] fold_y;

    // accept whenever the queue has room
    assign item.ready = can_push;
    assign push       = item.valid && can_push;

    // sign-extended load position
    assign raw_x = {{(K_W-DATA_W){item.arg_x[DATA_W-1]}}, item.arg_x};
    assign raw_y = {{(K_W-DATA_W){item.arg_y[DATA_W-1]}}, item.arg_y};

    // collide: 2*tile - size, so the back end forms 2*pos - fold
    assign fold_x = $signed({item.arg_x[DATA_W-1], item.arg_x, 1'b0})
                  - $signed({{(K_W-BODY_W){1'b0}}, cfg.body_width});
    assign fold_y = $signed({item.arg_y[DATA_W-1], item.arg_y, 1'b0})
                  - $signed({{(K_W-BODY_W){1'b0}}, cfg.body_height});

    // build the queue entry
    always_comb
    begin
        push_op.cmd    = item.cmd;
        push_op.arg_x  = raw_x;
        push_op.arg_y  = raw_y;
        push_op.vel_x  = item.load_vel_x;
        push_op.vel_y  = item.load_vel_y;
        push_op.ground = item.ground_test;
        case (item.cmd)
            CMD_COLLIDE:
            begin
                push_op.arg_x = fold_x;
                push_op.arg_y = fold_y;
            end
            default:
            begin
                push_op.arg_x = raw_x;
                push_op.arg_y = raw_y;
            end
        endcase
    end

endmodule

[hdl/abts_queue.sv]
// Short command queue between front and back end.
// Depends on abts_pkg for the entry type and depth.
module abts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  abts_pkg::op_t push_op,
    output logic          can_push,
    input  logic          pop,
    output logic          head_valid,
    output abts_pkg::op_t head_op
);
    import abts_pkg::*;

    op_t            entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    assign can_push   = (count_reg != QCW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    // occupancy after this cycle's transfers
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

[hdl/abts_back.sv]
// Back end: holds the body state, runs load, move and collide through its
// phase sequencer and drives the result register. Depends on abts_pkg, abts_out_if.
module abts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  abts_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  abts_pkg::op_t  head_op,
    output logic           pop,
    abts_out_if.source     result
);
    import abts_pkg::*;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic signed [DATA_W-1:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);

    // body state
    logic signed [DATA_W-1:0] pos_x_reg, pos_x_next;
    logic signed [DATA_W-1:0] pos_y_reg, pos_y_next;
    logic signed [DATA_W-1:0] vel_x_reg, vel_x_next;
    logic signed [DATA_W-1:0] vel_y_reg, vel_y_next;
    logic                     on_ground_reg, on_ground_next;
    logic [1:0]               phase_reg, phase_next;

    // collide datapath registers
    logic signed [DEP_W-1:0] dep_x_reg, dep_y_reg;
    logic [MAG_W-1:0]        mag_x_reg, mag_y_reg;
    logic                    dpos_x_reg, dpos_y_reg;
    logic [PROD_W-1:0]       lhs_reg, rhs_reg;

    // result register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_pos_x_reg, out_pos_y_reg;
    logic signed [DATA_W-1:0] out_vel_x_reg, out_vel_y_reg;
    logic                     out_on_ground_reg;

    logic slot_free;
    logic finish;

    // collide stage one signals
    logic signed [DIST_W-1:0] dist_x, dist_y;
    logic signed [DIST_W-1:0] abs_x, abs_y;
    logic signed [DIST_W-1:0] reach_x, reach_y;
    logic signed [DIST_W-1:0] num_x, num_y;
    logic signed [DEP_W-1:0]  dep_x, dep_y;
    logic signed [DEP_W-1:0]  ndep_x, ndep_y;

    // move signals
    logic signed [DATA_W-1:0] cvel_x, cvel_y;
    logic signed [SAT_W-1:0]  pos_x_w;
    logic signed [SAT_W-1:0]  span_w;
    logic signed [SAT_W-1:0]  wrap_hi_w;
    logic [15:0]              ws_plus;
    logic                     wrap_over, wrap_under;

    // push-out sums
    logic signed [SAT_W-1:0] push_x_w, push_y_w;

    // clamp one velocity axis to +/- the speed limit
    function automatic logic signed [DATA_W-1:0] clampv(
        input logic signed [DATA_W-1:0] v,
        input logic [30:0]              m
    );
        logic signed [DATA_W:0]   vw;
        logic signed [DATA_W:0]   mw;
        logic signed [DATA_W-1:0] pm;
        vw = {v[DATA_W-1], v};
        mw = $signed({2'b00, m});
        pm = $signed({1'b0, m});
        if (vw > mw)
            clampv = pm;
        else if (vw < -mw)
            clampv = -pm;
        else
            clampv = v;
    endfunction

    assign slot_free = !out_valid_reg || result.ready;
    assign pop       = finish;

    // twice-scale distance and depth per axis
    assign dist_x  = $signed({pos_x_reg[DATA_W-1], pos_x_reg[DATA_W-1], pos_x_reg, 1'b0})
                   - $signed({head_op.arg_x[K_W-1], head_op.arg_x});
    assign dist_y  = $signed({pos_y_reg[DATA_W-1], pos_y_reg[DATA_W-1], pos_y_reg, 1'b0})
                   - $signed({head_op.arg_y[K_W-1], head_op.arg_y});
    assign abs_x   = dist_x[DIST_W-1] ? -dist_x : dist_x;
    assign abs_y   = dist_y[DIST_W-1] ? -dist_y : dist_y;
    assign reach_x = $signed({{(DIST_W-BODY_W){1'b0}}, cfg.body_width})
                   + (DIST_W'(1) <<< FRAC_BITS);
    assign reach_y = $signed({{(DIST_W-BODY_W){1'b0}}, cfg.body_height})
                   + (DIST_W'(1) <<< FRAC_BITS);
    assign num_x   = reach_x - abs_x;
    assign num_y   = reach_y - abs_y;
    // depths are always even at twice the scale, so the halving is exact
    assign dep_x   = num_x[DIST_W-1:1];
    assign dep_y   = num_y[DIST_W-1:1];
    assign ndep_x  = -dep_x;
    assign ndep_y  = -dep_y;

    // move: clamp and horizontal wrap thresholds
    assign cvel_x    = clampv(vel_x_reg, cfg.speed_limit);
    assign cvel_y    = clampv(vel_y_reg, cfg.speed_limit);
    assign pos_x_w   = {{(SAT_W-DATA_W){pos_x_reg[DATA_W-1]}}, pos_x_reg};
    assign ws_plus   = {1'b0, cfg.wrap_tiles} + 16'd1;
    assign span_w    = $signed({{(SAT_W-15){1'b0}}, cfg.wrap_tiles}) <<< FRAC_BITS;
    assign wrap_hi_w = $signed({{(SAT_W-16){1'b0}}, ws_plus}) <<< FRAC_BITS;
    assign wrap_over  = (pos_x_w >= wrap_hi_w);
    assign wrap_under = (pos_x_reg <= NEG_ONE);

    // collide: push out along the chosen axis
    assign push_x_w = dpos_x_reg
                    ? pos_x_w + {{(SAT_W-DEP_W){dep_x_reg[DEP_W-1]}}, dep_x_reg}
                    : pos_x_w - {{(SAT_W-DEP_W){dep_x_reg[DEP_W-1]}}, dep_x_reg};
    assign push_y_w = dpos_y_reg
                    ? {{(SAT_W-DATA_W){pos_y_reg[DATA_W-1]}}, pos_y_reg}
                      + {{(SAT_W-DEP_W){dep_y_reg[DEP_W-1]}}, dep_y_reg}
                    : {{(SAT_W-DATA_W){pos_y_reg[DATA_W-1]}}, pos_y_reg}
                      - {{(SAT_W-DEP_W){dep_y_reg[DEP_W-1]}}, dep_y_reg};

    // command sequencer and next state
    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        on_ground_next = on_ground_reg;
        phase_next     = phase_reg;
        finish         = 1'b0;
        if (head_valid)
        begin
            case (head_op.cmd)
                CMD_LOAD:
                begin
                    if (slot_free)
                    begin
                        pos_x_next = head_op.arg_x[DATA_W-1:0];
                        pos_y_next = head_op.arg_y[DATA_W-1:0];
                        vel_x_next = head_op.vel_x;
                        vel_y_next = head_op.vel_y;
                        finish     = 1'b1;
                    end
                end
                CMD_MOVE:
                begin
                    if (phase_reg == PH_FIRST)
                    begin
                        vel_x_next = cvel_x;
                        vel_y_next = cvel_y;
                        pos_x_next = sat32(pos_x_w + {{(SAT_W-DATA_W){cvel_x[DATA_W-1]}},
                                                      cvel_x});
                        pos_y_next = sat32({{(SAT_W-DATA_W){pos_y_reg[DATA_W-1]}}, pos_y_reg}
                                           + {{(SAT_W-DATA_W){cvel_y[DATA_W-1]}}, cvel_y});
                        phase_next = PH_SECOND;
                    end
                    else if (slot_free)
                    begin
                        if (wrap_over)
                            pos_x_next = sat32(pos_x_w - span_w);
                        else if (wrap_under)
                            pos_x_next = sat32(pos_x_w + span_w);
                        vel_y_next = sat32({{(SAT_W-DATA_W){vel_y_reg[DATA_W-1]}}, vel_y_reg}
                                           - $signed({{(SAT_W-16){1'b0}}, cfg.gravity_step}));
                        phase_next = PH_FIRST;
                        finish     = 1'b1;
                    end
                end
                CMD_COLLIDE:
                begin
                    if (phase_reg == PH_FIRST)
                        phase_next = PH_SECOND;
                    else if (phase_reg == PH_SECOND)
                        phase_next = PH_THIRD;
                    else if (slot_free)
                    begin
                        if (head_op.ground)
                        begin
                            if (lhs_reg > rhs_reg)
                            begin
                                vel_y_next = '0;
                                pos_y_next = sat32(push_y_w);
                                if (dpos_y_reg)
                                    on_ground_next = 1'b1;
                            end
                        end
                        else if (lhs_reg < rhs_reg)
                        begin
                            vel_x_next = '0;
                            pos_x_next = sat32(push_x_w);
                        end
                        phase_next = PH_FIRST;
                        finish     = 1'b1;
                    end
                end
                default:
                begin
                    // unused code reports the state unchanged
                    if (slot_free)
                        finish = 1'b1;
                end
            endcase
        end
    end

    // body state and sequencer phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            on_ground_reg <= 1'b0;
            phase_reg     <= PH_FIRST;
        end
        else
        begin
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            vel_x_reg     <= vel_x_next;
            vel_y_reg     <= vel_y_next;
            on_ground_reg <= on_ground_next;
            phase_reg     <= phase_next;
        end
    end

    // collide depths, then the cross-multiplied ratios
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_FIRST)
        begin
            dep_x_reg  <= dep_x;
            dep_y_reg  <= dep_y;
            mag_x_reg  <= dep_x[DEP_W-1] ? ndep_x[MAG_W-1:0] : dep_x[MAG_W-1:0];
            mag_y_reg  <= dep_y[DEP_W-1] ? ndep_y[MAG_W-1:0] : dep_y[MAG_W-1:0];
            dpos_x_reg <= !dist_x[DIST_W-1] && (dist_x != '0);
            dpos_y_reg <= !dist_y[DIST_W-1] && (dist_y != '0);
        end
        if (phase_reg == PH_SECOND)
        begin
            lhs_reg <= PROD_W'(mag_x_reg) * PROD_W'(cfg.body_height);
            rhs_reg <= PROD_W'(mag_y_reg) * PROD_W'(cfg.body_width);
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_pos_x_reg     <= pos_x_next;
            out_pos_y_reg     <= pos_y_next;
            out_vel_x_reg     <= vel_x_next;
            out_vel_y_reg     <= vel_y_next;
            out_on_ground_reg <= on_ground_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_pos_x     = out_pos_x_reg;
    assign result.out_pos_y     = out_pos_y_reg;
    assign result.out_vel_x     = out_vel_x_reg;
    assign result.out_vel_y     = out_vel_y_reg;
    assign result.out_on_ground = out_on_ground_reg;

endmodule

[hdl/aabb_tile_body_step_unit.sv]
// Top level of the AABB tile body step unit: configuration registers, front
// end, command queue and back end. Depends on abts_pkg, abts_in_if, abts_out_if.
//
// One body in signed Q16.16 is stepped by load, move and collide commands and
// every command returns one result with the state after the step. The front
// end takes a command in every cycle while the four-entry command queue has
// room; the back end, which owns the state, ends a load or an unused code in
// its first phase, runs a move as clamp and add, then wrap and gravity, and a
// collide as depths, the two depth-by-size products, then compare and push-out,
// and starts a command only once the last one has finished. The result register
// frees the back end as soon as a waiting result is taken. The user must write
// configuration only while the unit is idle; the block does not enforce it.
module aabb_tile_body_step_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [abts_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [abts_pkg::CFG_DATA_W-1:0]       cfg_data,
    abts_in_if.sink                               item,
    abts_out_if.source                            result
);
    import abts_pkg::*;

    cfg_t cfg_reg;
    logic can_push;
    logic push;
    op_t  push_op;
    logic pop;
    logic head_valid;
    op_t  head_op;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_limit  <= RST_SPEED_LIMIT;
            cfg_reg.wrap_tiles   <= RST_WRAP_TILES;
            cfg_reg.gravity_step <= RST_GRAVITY_STEP;
            cfg_reg.body_width   <= RST_BODY_WIDTH;
            cfg_reg.body_height  <= RST_BODY_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED_LIMIT:  cfg_reg.speed_limit  <= cfg_data[30:0];
                REG_WRAP_TILES:   cfg_reg.wrap_tiles   <= cfg_data[14:0];
                REG_GRAVITY_STEP: cfg_reg.gravity_step <= cfg_data[15:0];
                REG_BODY_WIDTH:   cfg_reg.body_width   <= cfg_data[22:0];
                REG_BODY_HEIGHT:  cfg_reg.body_height  <= cfg_data[22:0];
                default:          ;
            endcase
        end
    end

    // decode and accept
    abts_front u_front (
        .item     (item),
        .cfg      (cfg_reg),
        .can_push (can_push),
        .push     (push),
        .push_op  (push_op)
    );

    // command queue
    abts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .can_push   (can_push),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // execute and report
    abts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .result     (result)
    );

endmodule

[sim/abts_body_checker.sv]
// Checker for the AABB tile body step unit: tracks the body state and registers,
// predicts one result per accepted command and compares each result transfer.
// Depends on abts_pkg, abts_in_if and abts_out_if.
module abts_body_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [abts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abts_pkg::CFG_DATA_W-1:0]  cfg_data,
    abts_in_if                               item,
    abts_out_if                              result,
    output int                               mismatches,
    output int                               outstanding
);
    import abts_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic                     on_ground;
    } body_t;

    cfg_t  regs;
    body_t body;
    body_t body_q[$];
    body_t seen;
    body_t want;
    int    errs;

    // clip to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    function automatic longint absl(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // clamp one velocity axis to +/- limit
    function automatic logic signed [DATA_W-1:0] limit_speed(
        input logic signed [DATA_W-1:0] v, input longint lim);
        longint neg;
        neg = -lim;
        if (longint'(v) > lim)
            return lim[DATA_W-1:0];
        if (longint'(v) < neg)
            return neg[DATA_W-1:0];
        return v;
    endfunction

    // body state after one command
    function automatic body_t step_body(
        input body_t b, input cfg_t c, input logic [1:0] cmd,
        input logic signed [DATA_W-1:0] ax, input logic signed [DATA_W-1:0] ay,
        input logic signed [DATA_W-1:0] vx, input logic signed [DATA_W-1:0] vy,
        input logic ground);
        longint one, span, tiles, w, h;
        longint dist_x, dist_y, dep_x, dep_y, lhs, rhs;
        one = longint'(1) << FRAC_BITS;
        case (cmd)
            CMD_LOAD:
            begin
                b.pos_x = ax;
                b.pos_y = ay;
                b.vel_x = vx;
                b.vel_y = vy;
            end
            CMD_MOVE:
            begin
                b.vel_x = limit_speed(b.vel_x, longint'(c.speed_limit));
                b.vel_y = limit_speed(b.vel_y, longint'(c.speed_limit));
                b.pos_x = clip32(longint'(b.pos_x) + longint'(b.vel_x));
                b.pos_y = clip32(longint'(b.pos_y) + longint'(b.vel_y));
                // wrap once on the x position truncated toward zero
                span  = longint'(c.wrap_tiles) << FRAC_BITS;
                tiles = longint'(b.pos_x) / one;
                if (tiles > longint'(c.wrap_tiles))
                    b.pos_x = clip32(longint'(b.pos_x) - span);
                else if (tiles < 0)
                    b.pos_x = clip32(longint'(b.pos_x) + span);
                b.vel_y = clip32(longint'(b.vel_y) - longint'(c.gravity_step));
            end
            CMD_COLLIDE:
            begin
                // distances and depths at twice the scale
                w      = longint'(c.body_width);
                h      = longint'(c.body_height);
                dist_x = 2 * longint'(b.pos_x) + w - 2 * longint'(ax);
                dist_y = 2 * longint'(b.pos_y) + h - 2 * longint'(ay);
                dep_x  = (w + one - absl(dist_x)) / 2;
                dep_y  = (h + one - absl(dist_y)) / 2;
                lhs    = absl(dep_x) * h;
                rhs    = absl(dep_y) * w;
                if (ground)
                begin
                    if (lhs > rhs)
                    begin
                        b.vel_y = '0;
                        if (dist_y > 0)
                        begin
                            b.pos_y     = clip32(longint'(b.pos_y) + dep_y);
                            b.on_ground = 1'b1;
                        end
                        else
                            b.pos_y = clip32(longint'(b.pos_y) - dep_y);
                    end
                end
                else if (lhs < rhs)
                begin
                    b.vel_x = '0;
                    if (dist_x > 0)
                        b.pos_x = clip32(longint'(b.pos_x) + dep_x);
                    else
                        b.pos_x = clip32(longint'(b.pos_x) - dep_x);
                end
            end
            default: ;
        endcase
        return b;
    endfunction

    task automatic report_field(input string name,
        input logic signed [DATA_W-1:0] want_v, input logic signed [DATA_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want_v, got_v);
            errs++;
        end
    endtask

    // register writes, result check, then prediction of the new command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '{RST_SPEED_LIMIT, RST_WRAP_TILES, RST_GRAVITY_STEP,
                     RST_BODY_WIDTH, RST_BODY_HEIGHT};
            body = '{default: '0};
            body_q.delete();
            errs = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SPEED_LIMIT:  regs.speed_limit  = cfg_data[30:0];
                    REG_WRAP_TILES:   regs.wrap_tiles   = cfg_data[14:0];
                    REG_GRAVITY_STEP: regs.gravity_step = cfg_data[15:0];
                    REG_BODY_WIDTH:   regs.body_width   = cfg_data[22:0];
                    REG_BODY_HEIGHT:  regs.body_height  = cfg_data[22:0];
                    default: ;
                endcase
            end

            // result transfer
            if (result.valid && result.ready)
            begin
                seen.pos_x     = result.out_pos_x;
                seen.pos_y     = result.out_pos_y;
                seen.vel_x     = result.out_vel_x;
                seen.vel_y     = result.out_vel_y;
                seen.on_ground = result.out_on_ground;
                if (body_q.size() == 0)
                begin
                    $display("%0t mismatch: result transfer with nothing expected, pos %0d,%0d",
                             $time, seen.pos_x, seen.pos_y);
                    errs++;
                end
                else
                begin
                    want = body_q.pop_front();
                    report_field("pos_x", want.pos_x, seen.pos_x);
                    report_field("pos_y", want.pos_y, seen.pos_y);
                    report_field("vel_x", want.vel_x, seen.vel_x);
                    report_field("vel_y", want.vel_y, seen.vel_y);
                    report_field("on_ground", DATA_W'(want.on_ground),
                                 DATA_W'(seen.on_ground));
                end
            end

            // command transfer
            if (item.valid && item.ready)
            begin
                body = step_body(body, regs, item.cmd, item.arg_x, item.arg_y,
                                 item.load_vel_x, item.load_vel_y, item.ground_test);
                body_q = {body_q, body};
            end

            outstanding <= body_q.size();
            mismatches  <= errs;
        end
    end

endmodule

[sim/aabb_tile_body_step_unit_tb.sv]
// Testbench top for the AABB tile body step unit: clock, reset, register
// writes and command stimulus with random stalls; abts_body_checker does the
// prediction. Depends on abts_pkg, abts_in_if, abts_out_if and the checker.
module aabb_tile_body_step_unit_tb;
    import abts_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int Q_ONE       = 1 << FRAC_BITS;
    localparam int PHASE_ITEMS = 205;
    localparam int CALM_TAIL   = 150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 80;
    localparam int LIMIT       = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     outstanding;
    int                     cycles = 0;
    int                     sent = 0;
    int                     phase_count = 0;
    int                     calm_left = 0;
    bit                     quiet = 1'b0;
    bit                     held = 1'b0;
    longint                 cfg_ws;
    longint                 cfg_w;
    longint                 cfg_h;

    abts_in_if  item_ch ();
    abts_out_if result_ch ();

    aabb_tile_body_step_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    abts_body_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, calm stretches and one long hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && sent >= HOLD_AT)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (quiet)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        result_ch.ready <= 1'b0;
                        repeat ($urandom_range(1, 5)) @(posedge clk);
                    end
                    2:
                    begin
                        result_ch.ready <= 1'b1;
                        repeat ($urandom_range(20, 50)) @(posedge clk);
                    end
                    default:
                    begin
                        result_ch.ready <= 1'b1;
                        @(posedge clk);
                    end
                endcase
            end
        end
    end

    // offer one command and wait for its transfer
    task automatic send(input logic [1:0] cmd, input int ax, input int ay,
                        input int vx, input int vy, input bit g);
        if (!quiet)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 4) == 0)
            begin
                item_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(20, 50);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= cmd;
        item_ch.arg_x       <= ax;
        item_ch.arg_y       <= ay;
        item_ch.load_vel_x  <= vx;
        item_ch.load_vel_y  <= vy;
        item_ch.ground_test <= g;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sent++;
        if (cmd != CMD_NOP)
            phase_count++;
    endtask

    // wait until every result is back, then for the back-end latency
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input longint value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_config(input longint ms, input longint ws, input longint gs,
                              input longint bw, input longint bh);
        write_reg(REG_SPEED_LIMIT, ms);
        write_reg(REG_WRAP_TILES, ws);
        write_reg(REG_GRAVITY_STEP, gs);
        write_reg(REG_BODY_WIDTH, bw);
        write_reg(REG_BODY_HEIGHT, bh);
        cfg_we <= 1'b0;
        cfg_ws = ws;
        cfg_w  = bw;
        cfg_h  = bh;
    endtask

    // positions: small, anywhere, near the range ends, near the wrap edge
    function automatic int pick_pos();
        case ($urandom_range(0, 4))
            0: return int'($urandom_range(0, 128 * Q_ONE)) - 64 * Q_ONE;
            1: return $urandom();
            2: return 32'sh7FFF_FFFF - int'($urandom_range(0, 4 * Q_ONE));
            3: return 32'sh8000_0000 + int'($urandom_range(0, 4 * Q_ONE));
            default: return int'((cfg_ws + longint'($urandom_range(0, 2)) - 1) * Q_ONE
                                 + longint'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
        endcase
    endfunction

    function automatic int pick_vel();
        case ($urandom_range(0, 3))
            0, 1: return int'($urandom_range(0, 6 * Q_ONE)) - 3 * Q_ONE;
            2: return $urandom();
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // tile centre within the larger body size plus two tiles of a body at c
    function automatic int near(input int c);
        longint spread;
        spread = ((cfg_w > cfg_h) ? cfg_w : cfg_h) + 2 * Q_ONE;
        return int'(longint'(c) + longint'($urandom_range(0, 32'(2 * spread))) - spread);
    endfunction

    // load, a few moves, then collisions, now and then a move, around the loaded spot
    task automatic run_sequence();
        int px;
        int py;
        px = pick_pos();
        py = pick_pos();
        send(CMD_LOAD, px, py, pick_vel(), pick_vel(), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3))
            send(CMD_MOVE, $urandom(), $urandom(), $urandom(), $urandom(),
                 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(0, 4) == 0)
                send(CMD_MOVE, $urandom(), $urandom(), $urandom(), $urandom(),
                     1'($urandom_range(0, 1)));
            else
                send(CMD_COLLIDE, near(px), near(py), $urandom(), $urandom(),
                     1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_phase(input int n, input bit last);
        phase_count = 0;
        while (phase_count < n)
        begin
            if (last && phase_count >= n - CALM_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 6) == 0)
                send(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                     $urandom(), 1'($urandom_range(0, 1)));
            else
                run_sequence();
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.cmd         = CMD_LOAD;
        item_ch.arg_x       = '0;
        item_ch.arg_y       = '0;
        item_ch.load_vel_x  = '0;
        item_ch.load_vel_y  = '0;
        item_ch.ground_test = 1'b0;
        cfg_ws = longint'(RST_WRAP_TILES);
        cfg_w  = longint'(RST_BODY_WIDTH);
        cfg_h  = longint'(RST_BODY_HEIGHT);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain load, gravity, unused code
        send(CMD_LOAD, 0, 0, 0, 0, 1'b0);
        send(CMD_MOVE, 0, 0, 0, 0, 1'b0);
        send(CMD_NOP, $urandom(), $urandom(), $urandom(), $urandom(), 1'b1);
        // field extremes: clamp, saturating add, wrap from the top
        send(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        send(CMD_MOVE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 1'b1);
        // wrap past the world edge, truncation to zero, wrap below zero, exact edge
        send(CMD_LOAD, 4097 * Q_ONE + 100, 0, Q_ONE, 0, 1'b0);
        send(CMD_MOVE, 0, 0, 0, 0, 1'b0);
        send(CMD_LOAD, -32768, 0, 0, 0, 1'b0);
        send(CMD_MOVE, 0, 0, 0, 0, 1'b0);
        send(CMD_LOAD, -Q_ONE - 1, 0, 0, 0, 1'b0);
        send(CMD_MOVE, 0, 0, 0, 0, 1'b0);
        send(CMD_LOAD, 4096 * Q_ONE + 65535, 0, 0, 0, 1'b0);
        send(CMD_MOVE, 0, 0, 0, 0, 1'b0);
        // landing on a tile top, then a side test against the same tile
        send(CMD_LOAD, 0, 58982, 0, -Q_ONE, 1'b0);
        send(CMD_COLLIDE, 32768, 32768, 0, 0, 1'b1);
        send(CMD_COLLIDE, 32768, 32768, 0, 0, 1'b0);
        // load keeps the flag; equal ratios resolve nothing
        send(CMD_LOAD, 0, 0, Q_ONE, Q_ONE, 1'b0);
        send(CMD_COLLIDE, 0, 32768, 0, 0, 1'b1);
        send(CMD_COLLIDE, 0, 32768, 0, 0, 1'b0);
        // hit from below, pushed left, pushed right
        send(CMD_LOAD, 0, -58982, Q_ONE, Q_ONE, 1'b0);
        send(CMD_COLLIDE, 32768, 32768, 0, 0, 1'b1);
        send(CMD_LOAD, 45875, 0, Q_ONE, 0, 1'b0);
        send(CMD_COLLIDE, 2 * Q_ONE, Q_ONE, 0, 0, 1'b0);
        send(CMD_LOAD, -45875, 0, -Q_ONE, 0, 1'b0);
        send(CMD_COLLIDE, -Q_ONE, Q_ONE, 0, 0, 1'b0);
        // far tile, and push-out that saturates
        send(CMD_COLLIDE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 1'b1);
        send(CMD_LOAD, 32'sh7FFF_FFF5, 32'sh7FFF_FFF5, 0, 0, 1'b0);
        send(CMD_COLLIDE, 32'sh7FFF_FFFF - 40000, 32'sh7FFF_FFFF - 40000, 0, 0, 1'b1);
        send(CMD_COLLIDE, 32'sh7FFF_FFFF - 40000, 32'sh7FFF_FFFF - 40000, 0, 0, 1'b0);

        random_phase(PHASE_ITEMS, 1'b0);

        // largest speed, a body 64 tiles high, smallest world and width
        settle();
        set_config(64'd2147483647, 1, 65535, 1, 4194304);
        send(CMD_LOAD, 0, 0, 0, 32'sh8000_0000, 1'b0);
        send(CMD_MOVE, 0, 0, 0, 0, 1'b0);
        send(CMD_MOVE, 0, 0, 0, 0, 1'b0);
        random_phase(PHASE_ITEMS, 1'b0);

        // no speed, no gravity, widest world, a body 64 tiles wide and as thin as it can be
        settle();
        set_config(0, 32767, 0, 4194304, 1);
        random_phase(PHASE_ITEMS, 1'b0);

        settle();
        set_config(longint'($urandom_range(0, 8 * Q_ONE)), longint'($urandom_range(1, 32767)),
                   longint'($urandom_range(0, 65535)), longint'($urandom_range(1, 4 * Q_ONE)),
                   longint'($urandom_range(1, 4 * Q_ONE)));
        random_phase(PHASE_ITEMS, 1'b0);

        settle();
        set_config(longint'($urandom_range(0, 32'h7FFF_FFFF)),
                   longint'($urandom_range(1, 32767)),
                   longint'($urandom_range(0, 65535)), longint'($urandom_range(1, 4194304)),
                   longint'($urandom_range(1, 4194304)));
        random_phase(PHASE_ITEMS, 1'b1);

        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
